// File: rtl/transformed_box_extents_macros.svh
// Assertion helpers used by the top-level RTL
`ifndef TRANSFORMED_BOX_EXTENTS_MACROS_SVH
`define TRANSFORMED_BOX_EXTENTS_MACROS_SVH

// same-cycle implication
`define TBE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbe assertion failed");

// next-cycle implication
`define TBE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbe assertion failed");

`endif

// File: rtl/tbe_pkg.sv
package tbe_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int REQ_DATA_W  = 328;
   localparam int RSP_DATA_W  = 192;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_BOX    = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   localparam logic [1:0] ROW_W_TERM = 2'd3;
   localparam logic [1:0] COL_T      = 2'd3;
   localparam logic [1:0] COL_LAST   = 2'd2;
   localparam logic [2:0] CORNER_LAST = 3'd7;

   // control from sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic mul;
      logic acc;
      logic first;
   } mac_ctrl_type;

   // divider status back to sequencer
   typedef struct packed {
      logic done;
      logic zero_den;
   } div_stat_type;

endpackage

// File: rtl/tbe_mac.sv
module tbe_mac #(
   parameter int FRAC_BITS = tbe_pkg::FRAC_BITS
) (
   input  logic                             clock,
   input  tbe_pkg::mac_ctrl_type            ctrl,
   input  logic signed [tbe_pkg::DATA_W-1:0] coef,
   input  logic signed [tbe_pkg::DATA_W-1:0] coord,
   input  logic signed [tbe_pkg::DATA_W-1:0] coef_t,
   output logic signed [tbe_pkg::ACC_W-1:0]  acc
);

   logic signed [tbe_pkg::ACC_W-1:0] prod_ff, prod_in;
   logic signed [tbe_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [tbe_pkg::ACC_W-1:0] base;

   // exact product, registered
   assign prod_in = tbe_pkg::ACC_W'(coef) * tbe_pkg::ACC_W'(coord);

   // floored product folded into the row sum; the first term starts from t
   assign base   = ctrl.first ? tbe_pkg::ACC_W'(coef_t) : acc_ff;
   assign acc_in = base + (prod_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: rtl/tbe_div.sv
module tbe_div #(
   parameter int COORD_WIDTH = tbe_pkg::COORD_WIDTH,
   parameter int FRAC_BITS   = tbe_pkg::FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tbe_pkg::ACC_W-1:0]  num,
   input  logic signed [tbe_pkg::ACC_W-1:0]  den,
   output logic signed [COORD_WIDTH-1:0]     quot,
   output tbe_pkg::div_stat_type             stat
);

   localparam int AW    = tbe_pkg::ACC_W;
   localparam int QW    = AW + FRAC_BITS;
   localparam int CNT_W = $clog2(QW + 1);
   localparam logic [QW-1:0] LIM = (QW'(1) << (COORD_WIDTH - 1)) - QW'(1);

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic              zero_ff, zero_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [QW-1:0]     dvd_ff, dvd_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [AW:0]       rem_ff, rem_in;
   logic [AW-1:0]     md_ff, md_in;
   logic              neg_ff, neg_in;
   logic signed [COORD_WIDTH-1:0] res_ff, res_in;

   logic [AW-1:0] mn, md;
   logic [AW:0]   rem_sh;
   logic          ge;
   logic [QW-1:0] mag_sat;

   assign mn = num[AW-1] ? AW'(-num) : AW'(num);
   assign md = den[AW-1] ? AW'(-den) : AW'(den);

   // one quotient bit per cycle
   assign rem_sh = {rem_ff[AW-1:0], dvd_ff[QW-1]};
   assign ge     = rem_sh >= {1'b0, md_ff};

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      md_in   = md_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      mag_sat = quo_ff;
      if (start) begin
         zero_in = (den == '0);
         if (den == '0) begin
            done_in = 1'b1;
            if (num == '0) begin
               res_in = '0;
            end else if (num[AW-1]) begin
               res_in = -COORD_WIDTH'(LIM + QW'(1));
            end else begin
               res_in = COORD_WIDTH'(LIM);
            end
         end else begin
            busy_in = 1'b1;
            cnt_in  = CNT_W'(QW);
            dvd_in  = QW'(mn) << FRAC_BITS;
            quo_in  = '0;
            rem_in  = '0;
            md_in   = md;
            neg_in  = num[AW-1] ^ den[AW-1];
         end
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, md_ff} : rem_sh;
         quo_in = {quo_ff[QW-2:0], ge};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // saturate magnitude, then apply sign
         if (neg_ff) begin
            mag_sat = (quo_ff > LIM + QW'(1)) ? LIM + QW'(1) : quo_ff;
            res_in  = -COORD_WIDTH'(mag_sat);
         end else begin
            mag_sat = (quo_ff > LIM) ? LIM : quo_ff;
            res_in  = COORD_WIDTH'(mag_sat);
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      md_ff  <= md_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign quot          = res_ff;
   assign stat.done     = done_ff;
   assign stat.zero_den = zero_ff;

endmodule

// File: rtl/transformed_box_extents.sv
// Channel | Dir | Ports                  | Beat contents
// req     | in  | req_tvalid/tready      | tuser: action; tdata: row, coefs, box
// rsp     | out | rsp_tvalid/tready      | tuser: flags; tdata: six extents
//
// Load and finish beats leave the block idle; a box beat keeps it busy until
// all eight corners are folded. Per corner: four row sums on the one shared
// multiplier (a multiply and an accumulate step a term, one more per row) and
// three quotients on the bit-serial divider. The divider's one bit per cycle
// sets the rate. Reset is synchronous.
// Every request beat waits while an earlier result is still not taken.
`include "transformed_box_extents_macros.svh"

module transformed_box_extents #(
   parameter int COORD_WIDTH = tbe_pkg::COORD_WIDTH,
   parameter int FRAC_BITS   = tbe_pkg::FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row_index[1:0], coef_x, coef_y, coef_z, coef_t, min_x, min_y, min_z,
   // max_x, max_y, max_z (32 bits each), zero pad
   input  logic [tbe_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
   output logic [tbe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // nonempty, zero_w_seen
   output logic [1:0]                        rsp_tuser
);

   localparam int DW = tbe_pkg::DATA_W;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_MUL      = 6'b000010,
      S_ACC      = 6'b000100,
      S_DIV_GO   = 6'b001000,
      S_DIV_WAIT = 6'b010000,
      S_FOLD     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [DW-1:0] rows_ff [16];
   logic signed [DW-1:0] lo_ff [3];
   logic signed [DW-1:0] hi_ff [3];
   logic signed [COORD_WIDTH-1:0] q_ff [3];
   logic signed [COORD_WIDTH-1:0] min_ff [3];
   logic signed [COORD_WIDTH-1:0] max_ff [3];
   logic signed [tbe_pkg::ACC_W-1:0] w_ff;
   logic [2:0] corner_ff;
   logic [1:0] row_ff, col_ff;
   logic       have_point_ff, w_fault_ff;
   logic       rsp_valid_ff;
   logic [tbe_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0] rsp_user_ff;

   logic       accept;
   logic [1:0] action, row_index;
   logic signed [DW-1:0] coef_sel, coord_sel, t_sel;
   logic signed [tbe_pkg::ACC_W-1:0] acc;
   logic signed [COORD_WIDTH-1:0]   quot;
   tbe_pkg::mac_ctrl_type mac_ctrl;
   tbe_pkg::div_stat_type div_stat;
   logic div_start;

   assign action    = req_tuser;
   assign row_index = req_tdata[1:0];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // operand selection for the shared multiplier
   assign coef_sel  = rows_ff[{row_ff, col_ff}];
   assign t_sel     = rows_ff[{row_ff, tbe_pkg::COL_T}];
   always_comb begin
      case (col_ff)
         2'd0:    coord_sel = corner_ff[0] ? hi_ff[0] : lo_ff[0];
         2'd1:    coord_sel = corner_ff[1] ? hi_ff[1] : lo_ff[1];
         default: coord_sel = corner_ff[2] ? hi_ff[2] : lo_ff[2];
      endcase
   end

   assign mac_ctrl.mul   = (state_ff == S_MUL);
   assign mac_ctrl.acc   = (state_ff == S_ACC);
   assign mac_ctrl.first = (col_ff == 2'd0);
   assign div_start      = (state_ff == S_DIV_GO) && (row_ff != tbe_pkg::ROW_W_TERM);

   tbe_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .coef   (coef_sel),
      .coord  (coord_sel),
      .coef_t (t_sel),
      .acc    (acc)
   );

   tbe_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc),
      .den   (w_ff),
      .quot  (quot),
      .stat  (div_stat)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && action == tbe_pkg::ACT_BOX) state_in = S_MUL;
         end
         S_MUL:  state_in = S_ACC;
         S_ACC: begin
            state_in = (col_ff == tbe_pkg::COL_LAST) ? S_DIV_GO : S_MUL;
         end
         S_DIV_GO: begin
            state_in = (row_ff == tbe_pkg::ROW_W_TERM) ? S_MUL : S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = (row_ff == 2'd2) ? S_FOLD : S_MUL;
            end
         end
         S_FOLD: begin
            state_in = (corner_ff == tbe_pkg::CORNER_LAST) ? S_IDLE : S_MUL;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         have_point_ff <= 1'b0;
         w_fault_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 16; i++) rows_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         // result beat: set by a finish, dropped once taken
         if (accept && action == tbe_pkg::ACT_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            case (action)
               tbe_pkg::ACT_LOAD: begin
                  rows_ff[{row_index, 2'd0}] <= req_tdata[33:2];
                  rows_ff[{row_index, 2'd1}] <= req_tdata[65:34];
                  rows_ff[{row_index, 2'd2}] <= req_tdata[97:66];
                  rows_ff[{row_index, 2'd3}] <= req_tdata[129:98];
               end
               tbe_pkg::ACT_FINISH: begin
                  have_point_ff <= 1'b0;
                  w_fault_ff    <= 1'b0;
                  for (int i = 0; i < 3; i++) begin
                     min_ff[i] <= '0;
                     max_ff[i] <= '0;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == S_DIV_WAIT && div_stat.done && div_stat.zero_den) begin
            w_fault_ff <= 1'b1;
         end
         // fold the finished corner into the extents
         if (state_ff == S_FOLD) begin
            have_point_ff <= 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (!have_point_ff || q_ff[i] < min_ff[i]) min_ff[i] <= q_ff[i];
               if (!have_point_ff || q_ff[i] > max_ff[i]) max_ff[i] <= q_ff[i];
            end
         end
      end
   end

   // counters and payload
   always_ff @(posedge clock) begin
      if (accept && action == tbe_pkg::ACT_BOX) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= req_tdata[130 + 32*i +: 32];
            hi_ff[i] <= req_tdata[226 + 32*i +: 32];
         end
         corner_ff <= '0;
         row_ff    <= tbe_pkg::ROW_W_TERM;
         col_ff    <= '0;
      end
      if (accept && action == tbe_pkg::ACT_FINISH) begin
         for (int i = 0; i < 3; i++) begin
            rsp_data_ff[32*i +: 32]      <= have_point_ff ? 32'(min_ff[i]) : '0;
            rsp_data_ff[96 + 32*i +: 32] <= have_point_ff ? 32'(max_ff[i]) : '0;
         end
         rsp_user_ff <= {w_fault_ff, have_point_ff};
      end
      if (state_ff == S_ACC) begin
         col_ff <= (col_ff == tbe_pkg::COL_LAST) ? 2'd0 : col_ff + 2'd1;
      end
      if (state_ff == S_DIV_GO && row_ff == tbe_pkg::ROW_W_TERM) begin
         w_ff   <= acc;
         row_ff <= 2'd0;
      end
      if (state_ff == S_DIV_WAIT && div_stat.done) begin
         case (row_ff)
            2'd0:    q_ff[0] <= quot;
            2'd1:    q_ff[1] <= quot;
            default: q_ff[2] <= quot;
         endcase
         if (row_ff != 2'd2) row_ff <= row_ff + 2'd1;
      end
      if (state_ff == S_FOLD) begin
         corner_ff <= corner_ff + 3'd1;
         row_ff    <= tbe_pkg::ROW_W_TERM;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `TBE_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, state_ff == S_IDLE)
   `TBE_ASSERT_NXT(a_finish_clears, clock, reset,
      accept && action == tbe_pkg::ACT_FINISH,
      rsp_valid_ff && !have_point_ff && !w_fault_ff)
   `TBE_ASSERT_IMP(a_div_only_wait, clock, reset, div_stat.done,
      state_ff == S_DIV_WAIT)

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

// Scoreboard: mirrors the transform and extent accumulator, holds the
// extents still owed by the block and compares each response beat.
class extents_board;
   typedef struct {
      logic [31:0] ext[6];
      logic        nonempty;
      logic        zero_w;
   } extent_rec;

   logic signed [31:0] rows[16];
   logic signed [31:0] ext_min[3];
   logic signed [31:0] ext_max[3];
   bit                 have_point;
   bit                 w_fault;
   extent_rec          owed[$];
   int                 errors;

   function new();
      foreach (rows[i]) rows[i] = '0;
      for (int c = 0; c < 3; c++) begin
         ext_min[c] = '0;
         ext_max[c] = '0;
      end
      have_point = 0;
      w_fault = 0;
      errors = 0;
   endfunction

   function longint sat_sum(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(signed'(a)) + 65'(signed'(b));
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return longint'(s);
   endfunction

   function longint row_sum(int r, longint px, longint py, longint pz);
      longint s;
      longint p[3];
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      s = longint'(rows[r*4+3]);
      for (int c = 0; c < 3; c++)
         s = sat_sum(s, (longint'(rows[r*4+c]) * p[c]) >>> tbe_pkg::FRAC_BITS);
      return s;
   endfunction

   // saturating Q16.16 quotient; zero w gives the limit by sign of num
   function logic signed [31:0] quotient(longint num, longint den);
      logic [63:0]  mn, md;
      logic [127:0] q;
      bit           neg;
      mn = num < 0 ? 64'(-num) : 64'(num);
      md = den < 0 ? 64'(-den) : 64'(den);
      neg = (num < 0) != (den < 0);
      if (den == 0) begin
         w_fault = 1;
         if (num == 0) return 0;
         return num > 0 ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
      q = ({64'b0, mn} << tbe_pkg::FRAC_BITS) / {64'b0, md};
      if (neg) begin
         if (q > 128'h8000_0000) q = 128'h8000_0000;
         return 32'(-q);
      end
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      return 32'(q);
   endfunction

   // note an accepted request beat
   function void note_request(logic [1:0] act, logic [1:0] row, logic [31:0] f[10]);
      longint           p[3], w;
      logic signed [31:0] q;
      extent_rec        rec;
      case (act)
         tbe_pkg::ACT_LOAD: begin
            for (int c = 0; c < 4; c++) rows[row*4+c] = f[c];
         end
         tbe_pkg::ACT_BOX: begin
            for (int k = 0; k < 8; k++) begin
               for (int c = 0; c < 3; c++)
                  p[c] = longint'(signed'(((k >> c) & 1) ? f[7+c] : f[4+c]));
               w = row_sum(tbe_pkg::ROW_W_TERM, p[0], p[1], p[2]);
               for (int c = 0; c < 3; c++) begin
                  q = quotient(row_sum(c, p[0], p[1], p[2]), w);
                  if (!have_point || q < ext_min[c]) ext_min[c] = q;
                  if (!have_point || q > ext_max[c]) ext_max[c] = q;
               end
               have_point = 1;
            end
         end
         tbe_pkg::ACT_FINISH: begin
            for (int c = 0; c < 3; c++) begin
               rec.ext[c]   = have_point ? ext_min[c] : '0;
               rec.ext[3+c] = have_point ? ext_max[c] : '0;
               ext_min[c] = '0;
               ext_max[c] = '0;
            end
            rec.nonempty = have_point;
            rec.zero_w = w_fault;
            owed.push_back(rec);
            have_point = 0;
            w_fault = 0;
         end
         default: ;
      endcase
   endfunction

   // compare a response beat with the oldest owed result
   function void check_response(logic [191:0] data, logic [1:0] user);
      extent_rec rec;
      if (owed.size() == 0) begin
         $display("%0t: unexpected response beat %h/%b", $time, data, user);
         errors++;
         return;
      end
      rec = owed.pop_front();
      for (int i = 0; i < 6; i++)
         if (data[i*32 +: 32] !== rec.ext[i]) begin
            $display("%0t: extent %0d expected %h actual %h", $time, i, rec.ext[i],
                     data[i*32 +: 32]);
            errors++;
         end
      if (user[0] !== rec.nonempty) begin
         $display("%0t: nonempty expected %b actual %b", $time, rec.nonempty, user[0]);
         errors++;
      end
      if (user[1] !== rec.zero_w) begin
         $display("%0t: zero_w_seen expected %b actual %b", $time, rec.zero_w, user[1]);
         errors++;
      end
   endfunction
endclass

module tb_top;

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           req_tvalid = 0;
   logic                           req_tready;
   logic [tbe_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 0;
   logic [tbe_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;

   extents_board board = new();
   bit           calm = 0;
   int           quiet_cycles = 0;
   logic [31:0]  fld[10];

   always #1 clock = ~clock;

   transformed_box_extents u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // response monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= 40000) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // response back-pressure in bursts
   initial begin
      @(posedge clock);
      forever begin
         rsp_tready <= 1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // one request beat; holds until accepted
   task automatic send_beat(logic [1:0] act, logic [1:0] row);
      logic [tbe_pkg::REQ_DATA_W-1:0] d;
      d = '0;
      d[1:0] = row;
      for (int i = 0; i < 10; i++) d[2 + i*32 +: 32] = fld[i];
      req_tvalid <= 1;
      req_tuser <= act;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      board.note_request(act, row, fld);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic load_row(logic [1:0] row, logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] cz, logic [31:0] ct);
      fld[0] = cx; fld[1] = cy; fld[2] = cz; fld[3] = ct;
      for (int i = 4; i < 10; i++) fld[i] = $urandom;
      send_beat(tbe_pkg::ACT_LOAD, row);
   endtask

   task automatic send_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                           logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
      for (int i = 0; i < 4; i++) fld[i] = $urandom;
      fld[4] = lx; fld[5] = ly; fld[6] = lz;
      fld[7] = hx; fld[8] = hy; fld[9] = hz;
      send_beat(tbe_pkg::ACT_BOX, 2'($urandom));
   endtask

   task automatic send_plain(logic [1:0] act);
      for (int i = 0; i < 10; i++) fld[i] = $urandom;
      send_beat(act, 2'($urandom));
   endtask

   // mostly modest Q16.16 values, some full-range and extremes
   function automatic logic [31:0] pick_val();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         4: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
         default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   task automatic wait_drained();
      req_tvalid <= 0;
      do @(posedge clock); while (board.owed.size() != 0);
      repeat (2200) @(posedge clock);
   endtask

   localparam logic [31:0] ONE = 32'h0001_0000;

   initial begin
      int sent;
      int roll;
      for (int i = 0; i < 10; i++) fld[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty finish, identity, zero w, extremes, inverted box, no-op
      send_plain(tbe_pkg::ACT_FINISH);
      load_row(0, ONE, 0, 0, 0);
      load_row(1, 0, ONE, 0, 0);
      load_row(2, 0, 0, ONE, 0);
      send_box(32'hFFFE_0000, 32'hFFFF_0000, 0, ONE, 32'h0002_0000, 32'h0003_0000);
      send_plain(tbe_pkg::ACT_FINISH);
      load_row(tbe_pkg::ROW_W_TERM, 0, 0, 0, ONE);
      send_box(32'hFFFE_0000, 32'hFFFF_0000, 0, ONE, 32'h0002_0000, 32'h0003_0000);
      send_box(ONE, ONE, ONE, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
      send_plain(tbe_pkg::ACT_NOP);
      send_plain(tbe_pkg::ACT_FINISH);
      load_row(tbe_pkg::ROW_W_TERM, ONE, 0, 0, 0);
      send_box(32'hFFFF_0000, 0, 0, ONE, ONE, ONE);
      send_plain(tbe_pkg::ACT_FINISH);
      load_row(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      load_row(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      load_row(tbe_pkg::ROW_W_TERM, 0, 0, 0, 32'h0000_0001);
      send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_plain(tbe_pkg::ACT_FINISH);
      load_row(tbe_pkg::ROW_W_TERM, 0, 0, 0, 32'hFFFF_0000);
      send_box(32'hFFFF_FFFF, 0, 32'h0000_8000, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_plain(tbe_pkg::ACT_FINISH);
      send_plain(tbe_pkg::ACT_FINISH);

      // random: matrix loads, boxes, finishes, occasional no-ops
      sent = 0;
      while (sent < 900) begin
         if (sent == 450) wait_drained();
         if (sent >= 780) calm = 1;
         roll = $urandom_range(0, 99);
         if (roll < 3) send_plain(tbe_pkg::ACT_NOP);
         else begin
            if (roll < 40) begin
               if ($urandom_range(0, 4) == 0)
                  load_row(tbe_pkg::ROW_W_TERM, pick_val(), pick_val(), pick_val(),
                           $urandom_range(0, 3) == 0 ? 32'h0 : pick_val());
               else
                  load_row(2'($urandom), pick_val(), pick_val(), pick_val(), pick_val());
            end else if (roll < 72)
               send_box(pick_val(), pick_val(), pick_val(), pick_val(), pick_val(),
                        pick_val());
            else
               send_plain(tbe_pkg::ACT_FINISH);
            sent++;
         end
      end
      send_plain(tbe_pkg::ACT_FINISH);
      req_tvalid <= 0;

      do @(posedge clock); while (board.owed.size() != 0);
      repeat (50) @(posedge clock);
      if (board.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
